// ===== src/wpd_pkg.sv =====
// ---------------------------------------------------------------------------
// wpd_pkg: shared types and constants of the WAV PCM stream decoder
// Holds the byte and result transaction types, the status and result kind
// codes, and the RIFF and chunk tag constants.
// ---------------------------------------------------------------------------
package wpd_pkg;

  // One input transaction: a file byte and the mark on the final byte.
  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } byte_item_t;

  // One result transaction: a decoded sample or the end status.
  typedef struct packed {
    logic               result_kind;
    logic signed [15:0] sample;
    logic [31:0]        sample_rate;
    logic [2:0]         status;
    logic               last_of_run;
  } result_item_t;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] STATUS_OK          = 3'd0;
  localparam logic [2:0] STATUS_BAD_HEADER  = 3'd1;
  localparam logic [2:0] STATUS_BAD_FORMAT  = 3'd2;
  localparam logic [2:0] STATUS_DATA_EARLY  = 3'd3;
  localparam logic [2:0] STATUS_NO_SAMPLES  = 3'd4;
  localparam logic [2:0] STATUS_NO_DATA     = 3'd5;

  localparam logic [31:0] RIFF_TAG = 32'h5249_4646;  // "RIFF"
  localparam logic [31:0] WAVE_TAG = 32'h5741_5645;  // "WAVE"
  localparam logic [31:0] FMT_TAG  = 32'h666D_7420;  // "fmt "
  localparam logic [31:0] DATA_TAG = 32'h6461_7461;  // "data"

  localparam logic [15:0] EXT_FORMAT_TAG = 16'hFFFE;
  localparam logic [4:0]  FMT_CAP        = 5'd26;
  localparam logic [4:0]  FMT_MIN        = 5'd16;

endpackage

// ===== src/wav_pcm_stream_decoder.sv =====
// ---------------------------------------------------------------------------
// wav_pcm_stream_decoder: WAV byte stream to mono 16-bit PCM samples
// Parses the RIFF/WAVE header and chunks, captures the fmt chunk and turns
// data chunk bytes into mono samples followed by one end status.
// ---------------------------------------------------------------------------
// Each accepted byte's results are pushed into the four-entry result
// queue. Throughput: one byte per cycle while byte_ready is high; the
// queue drains one result per cycle while result_ready is high. byte_ready
// is high while the queue holds at most two results. Reset (rst,
// synchronous) returns the parser to the RIFF header phase and empties
// the result queue.
module wav_pcm_stream_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  wpd_pkg::byte_item_t  byte_data,
  output logic                 result_valid,
  input  logic                 result_ready,
  output wpd_pkg::result_item_t result_data
);
  import wpd_pkg::*;

  // Parse phases, one-hot.
  typedef enum logic [6:0] {
    PH_RIFF  = 7'b0000001,
    PH_CHUNK = 7'b0000010,
    PH_FMT   = 7'b0000100,
    PH_DATA  = 7'b0001000,
    PH_SKIP  = 7'b0010000,
    PH_PAD   = 7'b0100000,
    PH_DONE  = 7'b1000000
  } phase_t;

  // Parser state. Every field has a defined reset, and the final byte of a
  // file also returns all of it to that reset.
  phase_t             phase, phase_next;
  logic [3:0]         header_index, header_index_next;
  logic [31:0]        chunk_tag, chunk_tag_next;
  logic [31:0]        chunk_length, chunk_length_next;
  logic [32:0]        bytes_left, bytes_left_next;
  logic               pad_pending, pad_pending_next;
  logic [15:0]        format_tag, format_tag_next;
  logic [15:0]        channel_count, channel_count_next;
  logic [31:0]        rate_value, rate_value_next;
  logic [15:0]        bits_per_sample, bits_per_sample_next;
  logic [15:0]        subformat_word, subformat_word_next;
  logic [4:0]         format_bytes_seen, format_bytes_seen_next;
  logic               format_valid, format_valid_next;
  logic [1:0]         frame_byte_index, frame_byte_index_next;
  logic [7:0]         low_byte_hold, low_byte_hold_next;
  logic signed [17:0] channel_sum, channel_sum_next;
  logic               frame_seen, frame_seen_next;

  // Results caused by the byte in hand: at most one sample, then at most
  // one status. Both carry the rate as it stands after this byte's capture.
  logic               smp_emit;
  logic signed [15:0] smp_val;
  logic               st_emit;
  logic [2:0]         st_code;
  logic [31:0]        res_rate;

  // Result queue.
  result_item_t       queue [4];
  logic [1:0]         wr_ptr, rd_ptr;
  logic [2:0]         count;
  logic               accept, pop;
  logic [2:0]         push_count;
  result_item_t       smp_item, st_item, first_item;

  assign accept       = byte_valid && byte_ready;
  assign pop          = result_valid && result_ready;
  assign byte_ready   = (count <= 3'd2);
  assign result_valid = (count != 3'd0);
  assign result_data  = queue[rd_ptr];

  // The fmt chunk check, applied to the captured fields.
  function automatic logic fmt_ok(
    input logic [15:0] ftag,
    input logic [15:0] chans,
    input logic [31:0] rate,
    input logic [15:0] bits,
    input logic [15:0] subfmt,
    input logic [4:0]  seen
  );
    logic pcm;
    pcm = (ftag == 16'd1) ||
          (ftag == EXT_FORMAT_TAG && seen >= FMT_CAP && subfmt == 16'd1);
    return (seen >= FMT_MIN) && pcm &&
           (chans == 16'd1 || chans == 16'd2) &&
           (bits == 16'd8 || bits == 16'd16) && (rate != 32'd0);
  endfunction

  always_comb begin
    logic [7:0]         b;
    logic               eof;
    logic [3:0]         hi_inc;
    logic [32:0]        bl_dec;
    logic [31:0]        tag_v;
    logic [31:0]        len_v;
    logic [4:0]         k;
    logic               bad;
    logic               wide;
    logic               stereo;
    logic [2:0]         frame_bytes;
    logic [2:0]         idx_inc;
    logic signed [17:0] sum_v;
    logic signed [17:0] avg;

    b   = byte_data.file_byte;
    eof = byte_data.end_of_file;

    phase_next             = phase;
    header_index_next      = header_index;
    chunk_tag_next         = chunk_tag;
    chunk_length_next      = chunk_length;
    bytes_left_next        = bytes_left;
    pad_pending_next       = pad_pending;
    format_tag_next        = format_tag;
    channel_count_next     = channel_count;
    rate_value_next        = rate_value;
    bits_per_sample_next   = bits_per_sample;
    subformat_word_next    = subformat_word;
    format_bytes_seen_next = format_bytes_seen;
    format_valid_next      = format_valid;
    frame_byte_index_next  = frame_byte_index;
    low_byte_hold_next     = low_byte_hold;
    channel_sum_next       = channel_sum;
    frame_seen_next        = frame_seen;

    smp_emit = 1'b0;
    smp_val  = '0;
    st_emit  = 1'b0;
    st_code  = STATUS_OK;

    hi_inc      = header_index + 4'd1;
    bl_dec      = bytes_left - 33'd1;
    tag_v       = (header_index == 4'd0) ? 32'd0 : chunk_tag;
    len_v       = (header_index == 4'd0) ? 32'd0 : chunk_length;
    k           = format_bytes_seen;
    wide        = (bits_per_sample == 16'd16);
    stereo      = (channel_count == 16'd2);
    frame_bytes = wide ? (stereo ? 3'd4 : 3'd2) : (stereo ? 3'd2 : 3'd1);
    idx_inc     = {1'b0, frame_byte_index} + 3'd1;
    sum_v       = channel_sum;
    avg         = '0;
    bad         = 1'b0;

    case (phase)
      PH_RIFF: begin
        // Bytes 0-3 must spell RIFF and bytes 8-11 WAVE; 4-7 are the size.
        bad = (header_index < 4'd4 &&
               b != RIFF_TAG[{~header_index[1:0], 3'b000} +: 8]) ||
              (header_index >= 4'd8 &&
               b != WAVE_TAG[{~header_index[1:0], 3'b000} +: 8]);
        if (bad) begin
          st_emit    = 1'b1;
          st_code    = STATUS_BAD_HEADER;
          phase_next = PH_DONE;
        end else if (hi_inc >= 4'd12) begin
          header_index_next = 4'd0;
          phase_next        = PH_CHUNK;
        end else begin
          header_index_next = hi_inc;
        end
      end
      PH_CHUNK: begin
        // Tag bytes arrive big-end first; the length is little-endian.
        if (header_index < 4'd4) begin
          tag_v = {tag_v[23:0], b};
        end else begin
          len_v[{header_index[1:0], 3'b000} +: 8] = b;
        end
        chunk_tag_next    = tag_v;
        chunk_length_next = len_v;
        header_index_next = hi_inc;
        if (hi_inc >= 4'd8) begin
          header_index_next = 4'd0;
          pad_pending_next  = len_v[0];
          if (tag_v == FMT_TAG) begin
            format_tag_next        = '0;
            channel_count_next     = '0;
            rate_value_next        = '0;
            bits_per_sample_next   = '0;
            subformat_word_next    = '0;
            format_bytes_seen_next = '0;
            format_valid_next      = 1'b0;
            bytes_left_next        = {1'b0, len_v};
            phase_next             = PH_FMT;
            // An empty fmt chunk can never pass the check.
            if (len_v == 32'd0) begin
              st_emit    = 1'b1;
              st_code    = STATUS_BAD_FORMAT;
              phase_next = PH_DONE;
            end
          end else if (tag_v == DATA_TAG) begin
            if (!format_valid) begin
              st_emit    = 1'b1;
              st_code    = STATUS_DATA_EARLY;
              phase_next = PH_DONE;
            end else begin
              frame_byte_index_next = '0;
              channel_sum_next      = '0;
              frame_seen_next       = 1'b0;
              bytes_left_next       = {1'b0, len_v};
              phase_next            = PH_DATA;
              if (len_v == 32'd0) begin
                st_emit    = 1'b1;
                st_code    = STATUS_NO_SAMPLES;
                phase_next = PH_DONE;
              end
            end
          end else begin
            // Unknown chunk: skip its body and its pad byte together.
            bytes_left_next = {1'b0, len_v} + {32'd0, len_v[0]};
            phase_next      = (len_v != 32'd0) ? PH_SKIP : PH_CHUNK;
          end
        end
      end
      PH_FMT: begin
        if (k < FMT_CAP) begin
          if (k < 5'd2) begin
            format_tag_next[{k[0], 3'b000} +: 8] = b;
          end else if (k < 5'd4) begin
            channel_count_next[{k[0], 3'b000} +: 8] = b;
          end else if (k < 5'd8) begin
            rate_value_next[{k[1:0], 3'b000} +: 8] = b;
          end else if (k == 5'd14 || k == 5'd15) begin
            bits_per_sample_next[{k[0], 3'b000} +: 8] = b;
          end else if (k == 5'd24 || k == 5'd25) begin
            subformat_word_next[{k[0], 3'b000} +: 8] = b;
          end
          format_bytes_seen_next = k + 5'd1;
        end
        bytes_left_next = bl_dec;
        if (bl_dec == 33'd0) begin
          if (fmt_ok(format_tag_next, channel_count_next, rate_value_next,
                     bits_per_sample_next, subformat_word_next,
                     format_bytes_seen_next)) begin
            format_valid_next = 1'b1;
            phase_next        = pad_pending ? PH_PAD : PH_CHUNK;
          end else begin
            st_emit    = 1'b1;
            st_code    = STATUS_BAD_FORMAT;
            phase_next = PH_DONE;
          end
        end
      end
      PH_DATA: begin
        if (!wide) begin
          // Unsigned 8-bit minus 128 is the byte with its top bit flipped.
          sum_v = channel_sum + 18'(signed'({~b[7], b[6:0], 8'h00}));
        end else if (!frame_byte_index[0]) begin
          low_byte_hold_next = b;
        end else begin
          sum_v = channel_sum + 18'(signed'({b, low_byte_hold}));
        end
        if (idx_inc >= frame_bytes) begin
          // Halve toward zero: add one to a negative sum before the shift.
          avg = (sum_v + {17'd0, sum_v[17]}) >>> 1;
          smp_emit              = 1'b1;
          smp_val               = stereo ? avg[15:0] : sum_v[15:0];
          frame_seen_next       = 1'b1;
          channel_sum_next      = '0;
          frame_byte_index_next = '0;
        end else begin
          channel_sum_next      = sum_v;
          frame_byte_index_next = idx_inc[1:0];
        end
        bytes_left_next = bl_dec;
        if (bl_dec == 33'd0) begin
          st_emit    = 1'b1;
          st_code    = frame_seen_next ? STATUS_OK : STATUS_NO_SAMPLES;
          phase_next = PH_DONE;
        end
      end
      PH_SKIP: begin
        bytes_left_next = bl_dec;
        if (bl_dec == 33'd0) begin
          phase_next = PH_CHUNK;
        end
      end
      PH_PAD: begin
        pad_pending_next = 1'b0;
        phase_next       = PH_CHUNK;
      end
      default: begin
      end
    endcase

    res_rate = rate_value_next;

    if (eof) begin
      // A file that ends before any status gets one from where it stands.
      if (phase_next != PH_DONE) begin
        st_emit = 1'b1;
        case (phase_next)
          PH_RIFF: st_code = STATUS_BAD_HEADER;
          PH_FMT: begin
            st_code = fmt_ok(format_tag_next, channel_count_next, rate_value_next,
                             bits_per_sample_next, subformat_word_next,
                             format_bytes_seen_next) ? STATUS_NO_DATA
                                                     : STATUS_BAD_FORMAT;
          end
          PH_DATA: st_code = frame_seen_next ? STATUS_OK : STATUS_NO_SAMPLES;
          default: st_code = STATUS_NO_DATA;
        endcase
      end
      phase_next             = PH_RIFF;
      header_index_next      = '0;
      chunk_tag_next         = '0;
      chunk_length_next      = '0;
      bytes_left_next        = '0;
      pad_pending_next       = 1'b0;
      format_tag_next        = '0;
      channel_count_next     = '0;
      rate_value_next        = '0;
      bits_per_sample_next   = '0;
      subformat_word_next    = '0;
      format_bytes_seen_next = '0;
      format_valid_next      = 1'b0;
      frame_byte_index_next  = '0;
      low_byte_hold_next     = '0;
      channel_sum_next       = '0;
      frame_seen_next        = 1'b0;
    end
  end

  // Result transactions built from this byte's outcome.
  always_comb begin
    smp_item.result_kind = KIND_SAMPLE;
    smp_item.sample      = smp_val;
    smp_item.sample_rate = res_rate;
    smp_item.status      = STATUS_OK;
    smp_item.last_of_run = !st_emit;

    st_item.result_kind  = KIND_STATUS;
    st_item.sample       = '0;
    st_item.sample_rate  = res_rate;
    st_item.status       = st_code;
    st_item.last_of_run  = 1'b1;

    first_item = smp_emit ? smp_item : st_item;
    push_count = accept ? ({2'd0, smp_emit} + {2'd0, st_emit}) : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_RIFF;
      header_index      <= '0;
      chunk_tag         <= '0;
      chunk_length      <= '0;
      bytes_left        <= '0;
      pad_pending       <= 1'b0;
      format_tag        <= '0;
      channel_count     <= '0;
      rate_value        <= '0;
      bits_per_sample   <= '0;
      subformat_word    <= '0;
      format_bytes_seen <= '0;
      format_valid      <= 1'b0;
      frame_byte_index  <= '0;
      low_byte_hold     <= '0;
      channel_sum       <= '0;
      frame_seen        <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      chunk_tag         <= chunk_tag_next;
      chunk_length      <= chunk_length_next;
      bytes_left        <= bytes_left_next;
      pad_pending       <= pad_pending_next;
      format_tag        <= format_tag_next;
      channel_count     <= channel_count_next;
      rate_value        <= rate_value_next;
      bits_per_sample   <= bits_per_sample_next;
      subformat_word    <= subformat_word_next;
      format_bytes_seen <= format_bytes_seen_next;
      format_valid      <= format_valid_next;
      frame_byte_index  <= frame_byte_index_next;
      low_byte_hold     <= low_byte_hold_next;
      channel_sum       <= channel_sum_next;
      frame_seen        <= frame_seen_next;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count[1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + push_count - {2'd0, pop};
    end
  end

  // Queue entries carry payload only.
  always_ff @(posedge clk) begin
    if (push_count != 3'd0) begin
      queue[wr_ptr] <= first_item;
    end
    if (push_count == 3'd2) begin
      queue[wr_ptr + 2'd1] <= st_item;
    end
  end

endmodule

// ===== src/wpd_checker.sv =====
// ---------------------------------------------------------------------------
// wpd_checker: port-level checks of the WAV PCM stream decoder
// Watches the result channel for handshake and content rules over time.
// ---------------------------------------------------------------------------
module wpd_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  byte_valid,
  input logic                  byte_ready,
  input logic                  result_valid,
  input logic                  result_ready,
  input wpd_pkg::result_item_t result_data
);
  import wpd_pkg::*;

  // A stalled result transaction stays offered.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_data))
    else $error("result transaction dropped or changed while stalled");

  // The queue is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  // A status transaction closes its run, has a legal code and no sample.
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.result_kind == KIND_STATUS |->
      result_data.last_of_run && result_data.sample == 16'sd0 &&
      result_data.status <= STATUS_NO_DATA)
    else $error("malformed status transaction");

  // A sample transaction carries status zero.
  a_sample_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.result_kind == KIND_SAMPLE |->
      result_data.status == STATUS_OK)
    else $error("sample transaction with nonzero status");

  // With nothing left to deliver, the queue always has room for a byte.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !result_valid |-> byte_ready)
    else $error("byte refused while the result queue is empty");

endmodule

bind wav_pcm_stream_decoder wpd_checker u_wpd_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_ready   (byte_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);

// ===== dv/wav_pcm_stream_decoder_tb.sv =====
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the WAV PCM stream decoder
// Streams directed and random WAV files into the decoder, one byte per
// transaction. A behavioral parser predicts each sample and end status, and
// every result transaction is compared field by field with that prediction.
// ---------------------------------------------------------------------------
module testbench;
  import wpd_pkg::*;

  // Where the parser stands inside the file.
  typedef enum logic [2:0] {
    PH_RIFF, PH_CHUNK, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_DONE
  } parse_phase_t;

  localparam int LIMIT_TIME = 5_000_000;

  logic         clk = 1'b0;
  logic         rst;
  logic         byte_valid;
  logic         byte_ready;
  byte_item_t   byte_data;
  logic         result_valid;
  logic         result_ready;
  result_item_t result_data;

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int bytes_sent;

  // Results that the decoder still owes, oldest first.
  result_item_t pending_results[$];
  // The file being assembled before it is streamed out.
  logic [7:0]   file_buf[$];

  // Parser state of the predictor.
  parse_phase_t p_phase;
  int           p_hdr_idx;
  logic [31:0]  p_tag;
  logic [31:0]  p_len;
  longint       p_left;
  logic         p_pad;
  logic [15:0]  p_fmt_tag;
  logic [15:0]  p_channels;
  logic [31:0]  p_rate;
  logic [15:0]  p_bits;
  logic [15:0]  p_subfmt;
  int           p_fmt_seen;
  logic         p_fmt_valid;
  int           p_frame_idx;
  logic [7:0]   p_low;
  int           p_sum;
  logic         p_frame_seen;

  wav_pcm_stream_decoder u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_data    (byte_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Predictor
  // -------------------------------------------------------------------------

  function automatic void reset_parser();
    p_phase = PH_RIFF;
    p_hdr_idx = 0;
    p_tag = '0;
    p_len = '0;
    p_left = 0;
    p_pad = 1'b0;
    p_fmt_tag = '0;
    p_channels = '0;
    p_rate = '0;
    p_bits = '0;
    p_subfmt = '0;
    p_fmt_seen = 0;
    p_fmt_valid = 1'b0;
    p_frame_idx = 0;
    p_low = '0;
    p_sum = 0;
    p_frame_seen = 1'b0;
  endfunction

  // Every result carries the rate that is held at the moment it is made.
  function automatic void queue_result(logic kind, logic [15:0] smp, logic [2:0] st);
    result_item_t r;
    r.result_kind = kind;
    r.sample = smp;
    r.sample_rate = p_rate;
    r.status = st;
    r.last_of_run = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void end_with(logic [2:0] st);
    p_phase = PH_DONE;
    queue_result(KIND_STATUS, 16'd0, st);
  endfunction

  // The extensible tag only counts when the subformat bytes were captured.
  function automatic bit format_acceptable();
    bit pcm;
    pcm = (p_fmt_tag == 16'd1) ||
          (p_fmt_tag == EXT_FORMAT_TAG && p_fmt_seen >= FMT_CAP && p_subfmt == 16'd1);
    return p_fmt_seen >= FMT_MIN && pcm &&
           (p_channels == 16'd1 || p_channels == 16'd2) &&
           (p_bits == 16'd8 || p_bits == 16'd16) && p_rate != 32'd0;
  endfunction

  function automatic void finish_format();
    if (!format_acceptable()) begin
      end_with(STATUS_BAD_FORMAT);
    end else begin
      p_fmt_valid = 1'b1;
      p_phase = p_pad ? PH_PAD : PH_CHUNK;
    end
  endfunction

  function automatic void start_chunk();
    p_hdr_idx = 0;
    p_pad = p_len[0];
    if (p_tag == FMT_TAG) begin
      // A new fmt chunk throws away whatever the previous one held.
      p_fmt_tag = '0;
      p_channels = '0;
      p_rate = '0;
      p_bits = '0;
      p_subfmt = '0;
      p_fmt_seen = 0;
      p_fmt_valid = 1'b0;
      p_left = p_len;
      p_phase = PH_FMT;
      if (p_left == 0) finish_format();
    end else if (p_tag == DATA_TAG) begin
      if (!p_fmt_valid) begin
        end_with(STATUS_DATA_EARLY);
      end else begin
        p_frame_idx = 0;
        p_sum = 0;
        p_frame_seen = 1'b0;
        p_left = p_len;
        p_phase = PH_DATA;
        if (p_left == 0) end_with(STATUS_NO_SAMPLES);
      end
    end else begin
      // Skipped bodies include their pad byte; the sum may need 33 bits.
      p_left = p_len;
      p_left += p_pad;
      p_phase = (p_left != 0) ? PH_SKIP : PH_CHUNK;
    end
  endfunction

  function automatic void capture_format(logic [7:0] b);
    int k;
    k = p_fmt_seen;
    if (k >= FMT_CAP) return;
    if (k < 2) p_fmt_tag[8*k +: 8] = b;
    else if (k < 4) p_channels[8*(k-2) +: 8] = b;
    else if (k < 8) p_rate[8*(k-4) +: 8] = b;
    else if (k == 14 || k == 15) p_bits[8*(k-14) +: 8] = b;
    else if (k == 24 || k == 25) p_subfmt[8*(k-24) +: 8] = b;
    p_fmt_seen = k + 1;
  endfunction

  function automatic void take_sample_byte(logic [7:0] b);
    bit                 wide;
    bit                 stereo;
    int                 frame_bytes;
    int                 mono;
    logic signed [15:0] word;
    wide = (p_bits == 16'd16);
    stereo = (p_channels == 16'd2);
    frame_bytes = (wide ? 2 : 1) * (stereo ? 2 : 1);
    if (!wide) begin
      p_sum += (int'(b) - 128) * 256;
    end else if (p_frame_idx % 2 == 0) begin
      p_low = b;
    end else begin
      word = {b, p_low};
      p_sum += word;
    end
    p_frame_idx++;
    if (p_frame_idx >= frame_bytes) begin
      // Integer division truncates toward zero, as the channel average must.
      mono = stereo ? p_sum / 2 : p_sum;
      queue_result(KIND_SAMPLE, mono[15:0], STATUS_OK);
      p_frame_seen = 1'b1;
      p_sum = 0;
      p_frame_idx = 0;
    end
  endfunction

  // Works out the results that one accepted byte transaction causes.
  function automatic void decode_byte(logic [7:0] b, logic eof);
    int queued_at_start;
    bit bad;
    queued_at_start = pending_results.size();
    case (p_phase)
      PH_RIFF: begin
        if (p_hdr_idx < 4) bad = (b != RIFF_TAG[8*(3-p_hdr_idx) +: 8]);
        else if (p_hdr_idx >= 8) bad = (b != WAVE_TAG[8*(11-p_hdr_idx) +: 8]);
        else bad = 1'b0;
        if (bad) begin
          end_with(STATUS_BAD_HEADER);
        end else begin
          p_hdr_idx++;
          if (p_hdr_idx >= 12) begin
            p_hdr_idx = 0;
            p_phase = PH_CHUNK;
          end
        end
      end
      PH_CHUNK: begin
        if (p_hdr_idx == 0) begin
          p_tag = '0;
          p_len = '0;
        end
        if (p_hdr_idx < 4) p_tag = {p_tag[23:0], b};
        else p_len[8*(p_hdr_idx-4) +: 8] = b;
        p_hdr_idx++;
        if (p_hdr_idx >= 8) start_chunk();
      end
      PH_FMT: begin
        capture_format(b);
        p_left--;
        if (p_left == 0) finish_format();
      end
      PH_DATA: begin
        take_sample_byte(b);
        p_left--;
        if (p_left == 0) end_with(p_frame_seen ? STATUS_OK : STATUS_NO_SAMPLES);
      end
      PH_SKIP: begin
        p_left--;
        if (p_left == 0) p_phase = PH_CHUNK;
      end
      PH_PAD: begin
        p_pad = 1'b0;
        p_phase = PH_CHUNK;
      end
      default: ;
    endcase
    // The final byte closes the file wherever parsing stands.
    if (eof) begin
      case (p_phase)
        PH_DONE: ;
        PH_RIFF: end_with(STATUS_BAD_HEADER);
        PH_FMT:  end_with(format_acceptable() ? STATUS_NO_DATA : STATUS_BAD_FORMAT);
        PH_DATA: end_with(p_frame_seen ? STATUS_OK : STATUS_NO_SAMPLES);
        default: end_with(STATUS_NO_DATA);
      endcase
      reset_parser();
    end
    if (pending_results.size() > queued_at_start) begin
      pending_results[pending_results.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Result side: random stalls and the checker
  // -------------------------------------------------------------------------

  always @(negedge clk) begin
    result_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic string describe(result_item_t r);
    return $sformatf("kind %0d sample %0d rate %0d status %0d last %0d",
                     r.result_kind, r.sample, r.sample_rate, r.status, r.last_of_run);
  endfunction

  always @(posedge clk) begin : check_results
    result_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %s", describe(result_data));
      end else begin
        want = pending_results.pop_front();
        if (result_data.result_kind !== want.result_kind ||
            result_data.sample !== want.sample ||
            result_data.sample_rate !== want.sample_rate ||
            result_data.status !== want.status ||
            result_data.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected %s", describe(want));
            $display("                 actual   %s", describe(result_data));
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Byte side
  // -------------------------------------------------------------------------

  // Entered and left at a falling edge. Valid is only dropped when a gap is
  // chosen, so back-to-back transactions keep it high without a glitch.
  task automatic send_byte(logic [7:0] b, logic eof);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    byte_valid <= 1'b1;
    byte_data <= '{file_byte: b, end_of_file: eof};
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    decode_byte(b, eof);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sends the first keep bytes of the assembled file, marking the last one.
  task automatic send_file(int keep);
    for (int i = 0; i < keep; i++) send_byte(file_buf[i], i == keep - 1);
    file_buf.delete();
  endtask

  // Holds the sender off until the decoder owes nothing; always advances.
  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  function automatic void append_byte(logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endfunction

  function automatic void put_tag(logic [31:0] t);
    for (int i = 3; i >= 0; i--) append_byte(t[8*i +: 8]);
  endfunction

  function automatic void put_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) append_byte(v[8*i +: 8]);
  endfunction

  // Pushes n bytes of a literal, leftmost byte first.
  function automatic void put_seq(logic [255:0] v, int n);
    for (int i = n - 1; i >= 0; i--) append_byte(v[8*i +: 8]);
  endfunction

  function automatic void put_random(int n);
    repeat (n) append_byte(8'($urandom_range(255)));
  endfunction

  function automatic void put_header();
    put_tag(RIFF_TAG);
    put_le($urandom, 4);
    put_tag(WAVE_TAG);
  endfunction

  function automatic void put_chunk_head(logic [31:0] tag, logic [31:0] len);
    put_tag(tag);
    put_le(len, 4);
  endfunction

  function automatic void put_other_chunk(int len);
    put_chunk_head($urandom, len);
    put_random(len + len % 2);
  endfunction

  // A fmt chunk of flen body bytes plus pad; fields outside the capture
  // window and the unused middle words are random.
  function automatic void put_fmt(logic [15:0] ftag, logic [15:0] ch, logic [31:0] rate,
                                  logic [15:0] width, int flen, logic [15:0] subfmt);
    put_chunk_head(FMT_TAG, flen);
    for (int k = 0; k < flen + flen % 2; k++) begin
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (k < 2) b = ftag[8*k +: 8];
      else if (k < 4) b = ch[8*(k-2) +: 8];
      else if (k < 8) b = rate[8*(k-4) +: 8];
      else if (k == 14 || k == 15) b = width[8*(k-14) +: 8];
      else if (k == 24 || k == 25) b = subfmt[8*(k-24) +: 8];
      append_byte(b);
    end
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // A wrong byte in either tag ends the file at once; the bytes after it
  // are ignored. A file cut inside the header also reports a bad header.
  task automatic test_bad_header();
    int cuts[3] = '{1, 6, 11};
    for (int p = 0; p < 12; p++) begin
      if (p >= 4 && p < 8) continue;
      put_header();
      file_buf[p] ^= 8'($urandom_range(1, 255));
      put_random(3);
      send_file(file_buf.size());
    end
    // The wrong byte is also the final byte.
    put_header();
    file_buf[9] ^= 8'h80;
    send_file(10);
    foreach (cuts[i]) begin
      put_header();
      send_file(cuts[i]);
    end
    // A complete header with nothing after it has no data chunk.
    put_header();
    send_file(12);
    append_byte(8'hFF);
    send_file(1);
    append_byte(8'h00);
    send_file(1);
  endtask

  task automatic sample_file(logic [15:0] ch, logic [15:0] width, logic [31:0] rate,
                             logic [255:0] data, int n);
    put_header();
    put_fmt(16'd1, ch, rate, width, 16, 16'd0);
    put_chunk_head(DATA_TAG, n);
    put_seq(data, n);
    put_random(2);
    send_file(file_buf.size());
  endtask

  // Full-scale values, mid-scale, channel averages that need truncation
  // toward zero, and trailing partial frames that must be dropped.
  task automatic test_sample_formats();
    sample_file(16'd1, 16'd8, 32'hFFFF_FFFF, 256'h00_FF_80_7F_81, 5);
    sample_file(16'd2, 16'd8, 32'd1, 256'h00_FF_FF_FF_00_00_80_7F_01, 9);
    sample_file(16'd1, 16'd16, 32'd44100, 256'h00_80_FF_7F_FF_FF_01_00_AA, 9);
    sample_file(16'd2, 16'd16, 32'd48000,
                256'h00_80_FF_7F_FF_FF_FE_FF_00_80_00_80_FF_7F_FF_7F_01_00_FF_FF_12_34_56,
                23);
  endtask

  task automatic format_case(logic [15:0] ftag, logic [15:0] ch, logic [31:0] rate,
                             logic [15:0] width, int flen, logic [15:0] subfmt);
    put_header();
    put_fmt(ftag, ch, rate, width, flen, subfmt);
    put_chunk_head(DATA_TAG, 8);
    put_random(8);
    send_file(file_buf.size());
  endtask

  task automatic test_format_checks();
    format_case(16'd3, 16'd1, 32'd8000, 16'd16, 16, 16'd0);
    format_case(EXT_FORMAT_TAG, 16'd2, 32'd44100, 16'd16, 26, 16'd1);
    format_case(EXT_FORMAT_TAG, 16'd1, 32'd44100, 16'd8, 26, 16'd3);
    // Extensible, but too short to reach the subformat word.
    format_case(EXT_FORMAT_TAG, 16'd1, 32'd44100, 16'd16, 18, 16'd1);
    // Longer than the capture window, so the count saturates.
    format_case(EXT_FORMAT_TAG, 16'd2, 32'd48000, 16'd8, 40, 16'd1);
    format_case(16'd1, 16'd0, 32'd8000, 16'd8, 16, 16'd0);
    format_case(16'd1, 16'd3, 32'd8000, 16'd8, 16, 16'd0);
    format_case(16'd1, 16'd1, 32'd8000, 16'd24, 16, 16'd0);
    format_case(16'd1, 16'd1, 32'd0, 16'd16, 16, 16'd0);
    format_case(16'd1, 16'd1, 32'd8000, 16'd16, 14, 16'd0);
    format_case(16'd1, 16'd1, 32'd8000, 16'd16, 0, 16'd0);
    format_case(16'd1, 16'd2, 32'd22050, 16'd8, 17, 16'd0);
    // A second fmt chunk replaces the first one.
    put_header();
    put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 16, 16'd0);
    put_fmt(16'd1, 16'd2, 32'd96000, 16'd16, 16, 16'd0);
    put_chunk_head(DATA_TAG, 8);
    put_random(8);
    send_file(file_buf.size());
  endtask

  task automatic test_chunk_order();
    int cut;
    int fmt_cuts[2] = '{16, 10};
    // Data chunk with no fmt chunk ahead of it.
    put_header();
    put_chunk_head(DATA_TAG, 4);
    put_random(4);
    send_file(file_buf.size());
    // Empty data chunk ends the file at its header.
    put_header();
    put_fmt(16'd1, 16'd1, 32'd16000, 16'd16, 16, 16'd0);
    put_chunk_head(DATA_TAG, 0);
    put_random(3);
    send_file(file_buf.size());
    // The file ends right after a valid fmt chunk.
    put_header();
    put_fmt(16'd1, 16'd2, 32'd11025, 16'd8, 16, 16'd0);
    send_file(file_buf.size());
    // Odd and empty foreign chunks and an odd fmt chunk are walked past.
    put_header();
    put_other_chunk(3);
    put_other_chunk(0);
    put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 17, 16'd0);
    put_other_chunk(1);
    put_chunk_head(DATA_TAG, 6);
    put_random(6);
    send_file(file_buf.size());
    // The file ends inside the fmt body: once after the checked fields,
    // once before them.
    foreach (fmt_cuts[i]) begin
      put_header();
      put_fmt(16'd1, 16'd1, 32'd8000, 16'd16, 18, 16'd0);
      send_file(20 + fmt_cuts[i]);
    end
    // The file ends inside a chunk header.
    put_header();
    put_chunk_head(FMT_TAG, 16);
    send_file(17);
    // The file ends on the pad byte of an odd fmt chunk.
    put_header();
    put_fmt(16'd1, 16'd1, 32'd8000, 16'd8, 17, 16'd0);
    send_file(file_buf.size());
    // The file ends inside a foreign chunk of the largest length.
    put_header();
    put_chunk_head($urandom, 32'hFFFF_FFFF);
    put_random(5);
    send_file(file_buf.size());
    // The file ends inside a long data chunk: after whole frames (sample
    // and status on one byte), then before any frame completes.
    for (int i = 0; i < 2; i++) begin
      cut = (i == 0) ? 8 : 3;
      put_header();
      put_fmt(16'd1, 16'd2, 32'd32000, 16'd16, 16, 16'd0);
      put_chunk_head(DATA_TAG, 32'hFFFF_FFFF);
      put_random(cut);
      send_file(file_buf.size());
    end
  endtask

  // Mostly well-formed files with random formats and content; the rest are
  // noise, files without a fmt chunk, files with one byte corrupted, and
  // files cut short at a random point.
  task automatic random_file();
    int          shape;
    int          keep;
    int          dlen;
    int          flen;
    int          pos;
    logic [15:0] ftag;
    logic [15:0] ch;
    logic [15:0] width;
    logic [15:0] subfmt;
    logic [31:0] rate;
    shape = $urandom_range(99);
    if (shape < 6) begin
      put_random($urandom_range(1, 16));
    end else begin
      put_header();
      repeat ($urandom_range(0, 2)) put_other_chunk($urandom_range(0, 5));
      if (shape >= 10) begin
        ch = ($urandom_range(15) == 0) ? 16'($urandom_range(3)) : 16'($urandom_range(1, 2));
        width = ($urandom_range(15) == 0) ? 16'($urandom_range(32)) :
                ($urandom_range(1) ? 16'd16 : 16'd8);
        rate = ($urandom_range(19) == 0) ? 32'd0 : $urandom;
        if ($urandom_range(3) == 0) begin
          ftag = EXT_FORMAT_TAG;
          subfmt = ($urandom_range(9) == 0) ? 16'd2 : 16'd1;
          flen = ($urandom_range(5) == 0) ? $urandom_range(16, 25) :
                 ($urandom_range(1) ? 26 : 40);
        end else begin
          ftag = ($urandom_range(19) == 0) ? 16'($urandom) : 16'd1;
          subfmt = 16'($urandom);
          flen = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(16, 19);
        end
        put_fmt(ftag, ch, rate, width, flen, subfmt);
        if ($urandom_range(4) == 0) put_other_chunk($urandom_range(0, 3));
      end
      dlen = ($urandom_range(7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 32);
      put_chunk_head(DATA_TAG, dlen);
      put_random(dlen + $urandom_range(0, 4));
      if (shape >= 10 && shape < 20) begin
        pos = $urandom_range(file_buf.size() - 1);
        file_buf[pos] ^= 8'($urandom_range(1, 255));
      end
    end
    keep = ($urandom_range(6) == 0) ? $urandom_range(1, file_buf.size()) : file_buf.size();
    send_file(keep);
  endtask

  // Each random phase starts from a drained decoder, which also gives the
  // sender its pause until every owed result has arrived.
  task automatic test_random_files(int send_pct, int recv_pct, int budget);
    int start_count;
    wait_drained();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start_count = bytes_sent;
    while (bytes_sent - start_count < budget) random_file();
  endtask

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_data = '0;
    send_idle_pct = 18;
    recv_idle_pct = 76;
    mismatches = 0;
    bytes_sent = 0;
    reset_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_bad_header();
    test_sample_formats();
    test_format_checks();
    test_chunk_order();
    test_random_files(18, 76, 80);
    test_random_files(76, 18, 80);
    test_random_files(0, 0, 80);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #LIMIT_TIME;
    $display("testbench failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/wpd_pkg.sv
src/wav_pcm_stream_decoder.sv
src/wpd_checker.sv
dv/wav_pcm_stream_decoder_tb.sv
